@@ sv/table_lagged_fibonacci_rng_assert.svh @@
// Assertion macros shared by the table lagged Fibonacci RNG RTL.
// Expects clk_i and rst_ni in the scope of every use; no other dependencies.
`ifndef TABLE_LAGGED_FIBONACCI_RNG_ASSERT_SVH
`define TABLE_LAGGED_FIBONACCI_RNG_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TLFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tlfr_pkg.sv @@
// Package for the table lagged Fibonacci RNG: widths, tap constants,
// the 256-byte permutation table and the status struct of the seed unit. No dependencies.
package tlfr_pkg;

  localparam int unsigned NUM_TAPS  = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OFS_W     = 8;
  localparam int unsigned ROM_BYTES = 256;
  localparam int unsigned ROM_WORDS = ROM_BYTES / 4;
  localparam int unsigned ROM_AW    = $clog2(ROM_WORDS);

  // Item codes on func.
  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // Tap order: index 0 = a, 1 = b, 2 = c, 3 = d.
  localparam logic [NUM_TAPS-1:0][OFS_W-1:0] TAP_STEP = {8'd28, 8'd24, 8'd12, 8'd4};
  localparam logic [NUM_TAPS-1:0][OFS_W-1:0] TAP_WRAP = {8'd244, 8'd236, 8'd212, 8'd188};
  localparam int unsigned SEED_MOD [NUM_TAPS] = '{47, 53, 59, 61};

  localparam logic [7:0] PERM_ROM [ROM_BYTES] = '{
    8'h8E, 8'h14, 8'h27, 8'h99, 8'hFD, 8'hAA, 8'hC7, 8'h08,
    8'hD5, 8'hE6, 8'h3E, 8'h1F, 8'hF6, 8'hBB, 8'h55, 8'hDA,
    8'h75, 8'hA0, 8'h4A, 8'h6A, 8'hE8, 8'hBD, 8'h97, 8'hFF,
    8'hDE, 8'h9B, 8'hBC, 8'h9F, 8'h81, 8'h8A, 8'hA1, 8'h46,
    8'h6E, 8'h0B, 8'hE3, 8'h63, 8'h76, 8'h7A, 8'h6C, 8'h5D,
    8'h88, 8'hD3, 8'h69, 8'hCA, 8'hC3, 8'h47, 8'hB9, 8'h25,
    8'h83, 8'hAB, 8'hA2, 8'h3F, 8'hA6, 8'h41, 8'h7C, 8'hBA,
    8'hE5, 8'hAC, 8'h95, 8'h01, 8'h7E, 8'hCF, 8'h09, 8'hC1,
    8'hD9, 8'h62, 8'h70, 8'h71, 8'h8D, 8'hDB, 8'h05, 8'h02,
    8'h24, 8'h87, 8'hEF, 8'h54, 8'hC6, 8'hD4, 8'h37, 8'h30,
    8'hD0, 8'h1B, 8'hCB, 8'h7B, 8'hB8, 8'hE4, 8'hD8, 8'hEC,
    8'h49, 8'hCE, 8'hAD, 8'hDC, 8'h13, 8'hA9, 8'h94, 8'hC4,
    8'h8F, 8'h39, 8'hAE, 8'h0D, 8'h18, 8'h52, 8'hDD, 8'h0E,
    8'h78, 8'hFA, 8'hF5, 8'h85, 8'h58, 8'hD2, 8'hAF, 8'h6D,
    8'hA4, 8'hB2, 8'h53, 8'h3B, 8'h51, 8'hA5, 8'h50, 8'hBE,
    8'hFC, 8'h2D, 8'hF4, 8'h11, 8'h48, 8'h98, 8'h16, 8'hF1,
    8'h86, 8'hDF, 8'h3D, 8'h66, 8'h5E, 8'h44, 8'h2E, 8'h2F,
    8'h36, 8'h07, 8'h6B, 8'h17, 8'h8B, 8'h29, 8'h4C, 8'hB6,
    8'hE2, 8'h89, 8'h5F, 8'hE7, 8'hCD, 8'hA7, 8'h21, 8'hE1,
    8'h4D, 8'hC9, 8'h65, 8'hED, 8'hFE, 8'hEE, 8'h9C, 8'h23,
    8'h33, 8'h7D, 8'hB7, 8'h04, 8'h9E, 8'h9A, 8'h2A, 8'h40,
    8'hB3, 8'h10, 8'h5B, 8'hF3, 8'h82, 8'h77, 8'h1C, 8'h92,
    8'h20, 8'h4E, 8'h1E, 8'h57, 8'h22, 8'h72, 8'h06, 8'h8C,
    8'h67, 8'h2C, 8'h73, 8'hFB, 8'h59, 8'hC2, 8'h0A, 8'hBF,
    8'h79, 8'h5C, 8'hF9, 8'h0C, 8'h28, 8'h1A, 8'h12, 8'h68,
    8'h74, 8'h34, 8'h19, 8'h42, 8'hB1, 8'hC0, 8'h84, 8'hF8,
    8'h38, 8'hF0, 8'h15, 8'h9D, 8'h60, 8'hF2, 8'h3A, 8'h6F,
    8'hB4, 8'h90, 8'hEB, 8'h91, 8'h1D, 8'h7F, 8'h35, 8'h61,
    8'h5A, 8'h32, 8'h03, 8'h56, 8'hA3, 8'hC5, 8'h2B, 8'h93,
    8'h80, 8'h0F, 8'h4B, 8'h43, 8'hF7, 8'hA8, 8'hE0, 8'h3C,
    8'h96, 8'hD1, 8'h64, 8'h26, 8'hD7, 8'h45, 8'hCC, 8'h4F,
    8'hC8, 8'hB0, 8'hE9, 8'hB5, 8'h00, 8'hD6, 8'h31, 8'hEA
  };

  // Little-endian dword at an aligned word index.
  function automatic logic [WORD_W-1:0] rom_word(input logic [ROM_AW-1:0] idx);
    rom_word = {PERM_ROM[{idx, 2'd3}], PERM_ROM[{idx, 2'd2}],
                PERM_ROM[{idx, 2'd1}], PERM_ROM[{idx, 2'd0}]};
  endfunction

  // Status of the seed reduction unit toward the top level.
  typedef struct packed {
    logic                               busy;
    logic                               valid;
    logic [NUM_TAPS-1:0][OFS_W-1:0]     ofs;
  } seed_ofs_t;

endpackage

@@ sv/tlfr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tlfr_seed_mod.sv @@
// Seed reduction: four byte offsets 4*(seed mod m) over a two-register pipeline.
// Depends on tlfr_pkg.
module tlfr_seed_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tlfr_pkg::WORD_W-1:0] seed_i,
  output tlfr_pkg::seed_ofs_t         status_o
);
  import tlfr_pkg::*;

  logic                 v1_q, v2_q;
  logic [15:0]          wsum1_q [NUM_TAPS];
  logic [15:0]          wsum2_q [NUM_TAPS];
  logic [9:0]           quot_q  [NUM_TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_lane
    localparam int unsigned M      = SEED_MOD[g];
    localparam logic [15:0] C1     = 16'(256 % M);
    localparam logic [15:0] C2     = 16'(65536 % M);
    localparam logic [15:0] C3     = 16'((2 ** 24) % M);
    localparam logic [31:0] RCP    = 32'((2 ** 22) / M);
    localparam logic [15:0] MOD16  = 16'(M);
    localparam logic [6:0]  MOD7   = 7'(M);

    logic [15:0] wsum_d;
    logic [31:0] prod;
    logic [15:0] rem16;
    logic [6:0]  rem7;
    logic [6:0]  rem_fix;

    // Fold bytes with their weights 256^k mod m; the sum stays below 2^16.
    assign wsum_d = 16'(seed_i[7:0]) + 16'(seed_i[15:8]) * C1
                  + 16'(seed_i[23:16]) * C2 + 16'(seed_i[31:24]) * C3;
    assign prod   = 32'(wsum1_q[g]) * RCP;

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        wsum1_q[g] <= wsum_d;
      end
      if (v1_q) begin
        wsum2_q[g] <= wsum1_q[g];
        quot_q[g]  <= prod[31:22];
      end
    end

    // Estimated quotient is exact or one short: one correction step.
    assign rem16   = wsum2_q[g] - 16'(quot_q[g]) * MOD16;
    assign rem7    = rem16[6:0];
    assign rem_fix = (rem7 >= MOD7) ? rem7 - MOD7 : rem7;
    assign status_o.ofs[g] = {rem_fix[5:0], 2'b00};
  end

  assign status_o.busy  = v1_q | v2_q;
  assign status_o.valid = v2_q;

endmodule

@@ sv/table_lagged_fibonacci_rng.sv @@
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | func_i, seed_i
//  out     | output    | out_valid_o/out_ready_i | value_o
//
//  After reset the four table copies are loaded with all 64 dwords; in_ready_o stays low meanwhile.
//  Draws pass table read, then mix and add, and stream at one per cycle while nothing stalls.
//  A seed beat blocks input while its modulo reduction runs.
//  A stalled result holds in the output register; the draw behind it waits in the mix stage.
//
// Top level of the table lagged Fibonacci RNG.
// Depends on tlfr_pkg, tlfr_ram, tlfr_seed_mod and table_lagged_fibonacci_rng_assert.svh.
module table_lagged_fibonacci_rng (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [tlfr_pkg::WORD_W-1:0] seed_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tlfr_pkg::WORD_W-1:0] value_o
);
  import tlfr_pkg::*;

  localparam int unsigned FILL_W = ROM_AW + 1;

  // Table load after reset: one dword into all four copies per cycle.
  logic [FILL_W-1:0] fill_cnt_q, fill_cnt_d;
  logic              fill_done;
  logic [ROM_AW-1:0] fill_addr;
  logic [WORD_W-1:0] fill_data;

  // Tap state, accumulator and the mix stage.
  logic [NUM_TAPS-1:0][OFS_W-1:0] offs_q, offs_d, ofs_step;
  logic [WORD_W-1:0]              acc_q, acc_d;
  logic                           s1_valid_q, s1_valid_d;
  logic                           s1_draw_q;
  logic [WORD_W-1:0]              s1_seed_q;
  logic                           out_valid_q, out_valid_d;
  logic [WORD_W-1:0]              value_q;

  logic              in_fire, draw_fire, seed_fire;
  logic              stall1, s1_go;
  logic [WORD_W-1:0] rd_word [NUM_TAPS];
  logic [WORD_W-1:0] mix, sum;
  seed_ofs_t         seed_st;

  assign fill_done = fill_cnt_q[FILL_W-1];
  assign fill_addr = fill_cnt_q[ROM_AW-1:0];
  assign fill_data = rom_word(fill_addr);
  assign fill_cnt_d = fill_done ? fill_cnt_q : fill_cnt_q + FILL_W'(1);

  // Handshake: drop ready while loading, while a seed reduces, or when the
  // mix stage holds a draw that cannot move into a full output register.
  assign stall1     = s1_valid_q & s1_draw_q & out_valid_q & ~out_ready_i;
  assign s1_go      = s1_valid_q & ~stall1;
  assign in_ready_o = fill_done & ~seed_st.busy & ~stall1;
  assign in_fire    = in_valid_i & in_ready_o;
  assign draw_fire  = in_fire & (func_i == FUNC_DRAW);
  assign seed_fire  = in_fire & (func_i == FUNC_SEED);

  // Step each offset back, wrapping inside its modulus.
  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (offs_q[i] >= TAP_STEP[i]) begin
        ofs_step[i] = offs_q[i] - TAP_STEP[i];
      end else begin
        ofs_step[i] = offs_q[i] + TAP_WRAP[i] - TAP_STEP[i];
      end
    end
  end

  // Seed offsets land when the reduction finishes; input is blocked until then.
  always_comb begin
    offs_d = offs_q;
    if (seed_st.valid) begin
      offs_d = seed_st.ofs;
    end else if (draw_fire) begin
      offs_d = ofs_step;
    end
  end

  tlfr_seed_mod u_seed_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (seed_fire),
    .seed_i   (seed_i),
    .status_o (seed_st)
  );

  // One table copy per tap, read at the freshly stepped offsets.
  for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
    tlfr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROM_WORDS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (~fill_done),
      .waddr_i (fill_addr),
      .wdata_i (fill_data),
      .re_i    (draw_fire),
      .raddr_i (ofs_step[t][OFS_W-1:2]),
      .rdata_o (rd_word[t])
    );
  end

  // Mix: rotate a, b, c left by 1, 2, 3, XOR with d, add the accumulator.
  assign mix = {rd_word[0][WORD_W-2:0], rd_word[0][WORD_W-1]}
             ^ {rd_word[1][WORD_W-3:0], rd_word[1][WORD_W-1:WORD_W-2]}
             ^ {rd_word[2][WORD_W-4:0], rd_word[2][WORD_W-1:WORD_W-3]}
             ^ rd_word[3];
  assign sum = mix + acc_q;

  // Accumulator updates in the mix stage, so the next draw sees it directly.
  always_comb begin
    acc_d = acc_q;
    if (s1_go) begin
      acc_d = s1_draw_q ? sum : s1_seed_q;
    end
  end

  assign s1_valid_d  = in_fire | (s1_valid_q & stall1);
  assign out_valid_d = (s1_go & s1_draw_q) | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q  <= '0;
      offs_q      <= '0;
      acc_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_cnt_q  <= fill_cnt_d;
      offs_q      <= offs_d;
      acc_q       <= acc_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the mix stage and the output register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_draw_q <= (func_i == FUNC_DRAW);
      s1_seed_q <= seed_i;
    end
    if (s1_go && s1_draw_q) begin
      value_q <= sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  `include "table_lagged_fibonacci_rng_assert.svh"

  `TLFR_ASSERT_NOW(a_no_accept_in_fill, in_fire, fill_done, "beat accepted during table load")
  `TLFR_ASSERT_NEXT(a_seed_blocks, seed_fire, !in_ready_o, "input open right after a seed beat")
  `TLFR_ASSERT_NOW(a_no_read_on_stall, stall1, !draw_fire, "table read issued while mix stage stalled")
  `TLFR_ASSERT_NEXT(a_draw_reaches_out, s1_go && s1_draw_q, out_valid_o, "draw lost in mix stage")
  `TLFR_ASSERT_NOW(a_ofs_aligned, 1'b1,
                   (offs_q[0][1:0] == 2'b00) && (offs_q[1][1:0] == 2'b00) &&
                   (offs_q[2][1:0] == 2'b00) && (offs_q[3][1:0] == 2'b00),
                   "tap offset not dword aligned")

endmodule
